/* design/bpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // Hold counter width and saturation value
  localparam int unsigned CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // Ignore window width (two events of 16-bit ignore_ticks never saturate it)
  localparam int unsigned IgnBits = 17;

  // Event codes
  localparam logic [2:0] EvUpShort   = 3'd0;
  localparam logic [2:0] EvUpLong    = 3'd1;
  localparam logic [2:0] EvDownShort = 3'd2;
  localparam logic [2:0] EvDownLong  = 3'd3;
  localparam logic [2:0] EvOn        = 3'd4;
  localparam logic [2:0] EvOn2       = 3'd5;
  localparam logic [2:0] EvOff       = 3'd6;

  // Release wait modes
  localparam logic [1:0] WaitNone = 2'd0;
  localparam logic [1:0] WaitOn   = 2'd1;
  localparam logic [1:0] WaitOff  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] RegShortTicks   = 3'd0;
  localparam logic [2:0] RegLongTicks    = 3'd1;
  localparam logic [2:0] RegOffTicks     = 3'd2;
  localparam logic [2:0] RegIgnoreTicks  = 3'd3;
  localparam logic [2:0] RegStartPowered = 3'd4;

  // Register reset values
  localparam logic [15:0] ShortTicksRst  = 16'd100;
  localparam logic [15:0] LongTicksRst   = 16'd1000;
  localparam logic [15:0] OffTicksRst    = 16'd4000;
  localparam logic [15:0] IgnoreTicksRst = 16'd300;
  localparam logic        StartPowRst    = 1'b0;

  // Result queue depth
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrBits   = $clog2(FifoDepth);

  typedef struct packed {
    logic       up_level;
    logic       down_level;
    logic       ext_valid;
    logic [2:0] ext_code;
  } in_req_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       powered;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic [15:0] short_ticks;
    logic [15:0] long_ticks;
    logic [15:0] off_ticks;
    logic [15:0] ignore_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 pwr_on;
    logic [1:0]           wait_mode;
    logic [CountBits-1:0] up_cnt;
    logic [CountBits-1:0] down_cnt;
    logic [IgnBits-1:0]   ign;
  } bpc_state_t;

  // Up to three results of one tick, packed to the front
  typedef struct packed {
    logic [1:0]         n;
    out_req_t [2:0]     ev;
  } bpc_res_t;

endpackage

`default_nettype wire

/* design/bpc_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module bpc_step import bpc_pkg::*; (
  input  wire cfg_t       cfg_i,
  input  wire bpc_state_t st_i,
  input  wire in_req_t    req_i,
  output bpc_state_t      nxt_o,
  output bpc_res_t        res_o
);

  logic                 up, down;
  logic [CountBits-1:0] down_inc;
  logic [2:0]           v;
  out_req_t [2:0]       e;
  logic [1:0]           n_add;
  logic                 off_now;
  logic [1:0]           pos1, pos2;

  assign up   = ~req_i.up_level;
  assign down = ~req_i.down_level;

  // Next state and candidate events in priority order
  always_comb begin
    nxt_o    = st_i;
    v        = '0;
    e        = '0;
    n_add    = 2'd0;
    off_now  = 1'b0;
    down_inc = (st_i.down_cnt != CountMax) ? st_i.down_cnt + 1'b1 : st_i.down_cnt;

    if (st_i.wait_mode == WaitOn) begin
      if (!up && !down) begin
        nxt_o.wait_mode = WaitNone;
        nxt_o.ign       = {1'b0, cfg_i.ignore_ticks};
      end
    end else if (st_i.wait_mode == WaitOff) begin
      if (!down) nxt_o.wait_mode = WaitNone;
    end else begin
      nxt_o.wait_mode = WaitNone;
      if (st_i.ign != '0) begin
        nxt_o.ign = st_i.ign - 1'b1;
      end else if (!st_i.pwr_on) begin
        if (up || down) begin
          nxt_o.pwr_on    = 1'b1;
          nxt_o.wait_mode = WaitOn;
          v[0]            = 1'b1;
          e[0].event_code = up ? EvOn : EvOn2;
          e[0].powered    = 1'b1;
        end
      end else begin
        // up button
        if (up) begin
          if (st_i.up_cnt != CountMax) nxt_o.up_cnt = st_i.up_cnt + 1'b1;
        end else begin
          if (st_i.up_cnt > cfg_i.long_ticks) begin
            v[0] = 1'b1;
            e[0].event_code = EvUpLong;
          end else if (st_i.up_cnt > cfg_i.short_ticks) begin
            v[0] = 1'b1;
            e[0].event_code = EvUpShort;
          end
          e[0].powered = 1'b1;
          nxt_o.up_cnt = '0;
        end
        // down button, with power-off by holding
        if (down) begin
          nxt_o.down_cnt = down_inc;
          if (down_inc > cfg_i.off_ticks) begin
            nxt_o.pwr_on     = 1'b0;
            nxt_o.wait_mode  = WaitOff;
            nxt_o.down_cnt   = '0;
            off_now          = 1'b1;
            v[1]             = 1'b1;
            e[1].event_code  = EvOff;
            e[1].powered     = 1'b0;
          end
        end else begin
          if (st_i.down_cnt > cfg_i.long_ticks) begin
            v[1] = 1'b1;
            e[1].event_code = EvDownLong;
          end else if (st_i.down_cnt > cfg_i.short_ticks) begin
            v[1] = 1'b1;
            e[1].event_code = EvDownShort;
          end
          e[1].powered   = 1'b1;
          nxt_o.down_cnt = '0;
        end
        // press events extend the ignore window (window is empty here)
        n_add = {1'b0, v[0]} + {1'b0, v[1] & ~off_now};
        case (n_add)
          2'd1:    nxt_o.ign = {1'b0, cfg_i.ignore_ticks};
          2'd2:    nxt_o.ign = {cfg_i.ignore_ticks, 1'b0};
          default: nxt_o.ign = '0;
        endcase
        // external event pass-through
        if (req_i.ext_valid && !off_now && req_i.ext_code <= EvOff) begin
          if (req_i.ext_code == EvOff) begin
            nxt_o.pwr_on = 1'b0;
          end else if (req_i.ext_code == EvOn || req_i.ext_code == EvOn2) begin
            nxt_o.pwr_on = 1'b1;
          end
          v[2]            = 1'b1;
          e[2].event_code = req_i.ext_code;
          e[2].powered    = nxt_o.pwr_on;
        end
      end
    end
  end

  // Pack valid events to the front and mark the final one
  assign pos1 = {1'b0, v[0]};
  assign pos2 = {1'b0, v[0]} + {1'b0, v[1]};

  always_comb begin
    res_o   = '0;
    res_o.n = pos2 + {1'b0, v[2]};
    if (v[0]) res_o.ev[0]    = e[0];
    if (v[1]) res_o.ev[pos1] = e[1];
    if (v[2]) res_o.ev[pos2] = e[2];
    if (res_o.n != 2'd0) res_o.ev[res_o.n - 2'd1].last = 1'b1;
  end

endmodule

`default_nettype wire

/* design/button_press_classifier_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------
// in       | input     | in_valid_i / in_stall_o    | in_req_i   (in_req_t)
// out      | output    | out_valid_o / out_stall_i  | out_req_o  (out_req_t)
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One tick is taken per cycle while the queue has room, held in an input register,
// and evaluated against the state; its zero to three events go into a four-entry
// result queue. The output port drains one event per cycle unless out_stall_i is
// high. A tick waits until the queue has room for three events. Reset is
// asynchronous: registers take their defaults, the machine powers off, the queue
// empties. Output stalls back up the queue, then the input.

module button_press_classifier_top import bpc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  cfg_t       cfg_q;
  bpc_state_t st_q, st_nxt;
  bpc_res_t   res;
  in_req_t    in_q;
  logic       in_vld_q;

  out_req_t [FifoDepth-1:0] mem_q;
  logic [PtrBits-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]         cnt_q, cnt_d;

  logic pop, room, proc, in_acc, cfg_we;
  logic [PtrBits:0] n_push;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Queue flow control
  assign pop         = out_valid_o & ~out_stall_i;
  assign room        = (cnt_q <= (PtrBits+1)'(FifoDepth - 3)) ||
                       ((cnt_q == (PtrBits+1)'(FifoDepth - 2)) && pop);
  assign proc        = in_vld_q & room;
  assign in_stall_o  = in_vld_q & ~proc;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign n_push      = proc ? (PtrBits+1)'(res.n) : '0;
  assign cnt_d       = cnt_q - (PtrBits+1)'(pop) + n_push;
  assign out_valid_o = (cnt_q != '0);
  assign out_req_o   = mem_q[rd_ptr_q];

  bpc_step u_step (
    .cfg_i (cfg_q),
    .st_i  (st_q),
    .req_i (in_q),
    .nxt_o (st_nxt),
    .res_o (res)
  );

  // Configuration registers and classifier state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_ticks  <= ShortTicksRst;
      cfg_q.long_ticks   <= LongTicksRst;
      cfg_q.off_ticks    <= OffTicksRst;
      cfg_q.ignore_ticks <= IgnoreTicksRst;
      st_q               <= '{pwr_on: StartPowRst, default: '0};
    end else begin
      if (cfg_we) begin
        case (cfg_index_i)
          RegShortTicks:   cfg_q.short_ticks  <= cfg_data_i;
          RegLongTicks:    cfg_q.long_ticks   <= cfg_data_i;
          RegOffTicks:     cfg_q.off_ticks    <= cfg_data_i;
          RegIgnoreTicks:  cfg_q.ignore_ticks <= cfg_data_i;
          default: ;
        endcase
      end
      if (cfg_we && cfg_index_i == RegStartPowered) begin
        st_q.pwr_on <= cfg_data_i[0];
      end else if (proc) begin
        st_q <= st_nxt;
      end
    end
  end

  // Input register control and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) in_vld_q <= 1'b1;
      else if (proc) in_vld_q <= 1'b0;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      wr_ptr_q <= wr_ptr_q + PtrBits'(n_push);
      cnt_q    <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_req_i;
    for (int j = 0; j < 3; j++) begin
      if (proc && (j < int'(res.n))) mem_q[wr_ptr_q + PtrBits'(j)] <= res.ev[j];
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(FifoDepth))
    else $error("result queue overfilled");

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> (cnt_q - (PtrBits+1)'(pop)) <= (PtrBits+1)'(FifoDepth - 3))
    else $error("tick evaluated without queue room");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && res.n != 2'd0) |=> out_valid_o)
    else $error("pushed event not presented");

  a_ign_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ign != {IgnBits{1'b1}})
    else $error("ignore window out of range");

endmodule

`default_nettype wire
